>>> hdl/gbpf_pkg.sv
// gbpf_pkg: shared codes and the command/status structs of the grid path finder
// used by gbpf_ctrl, gbpf_datapath and grid_bfs_path_finder_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gbpf_pkg;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_UNUSABLE = 2'd1;
  localparam logic [1:0] STAT_NO_PATH  = 2'd2;
  localparam logic [1:0] STAT_BEYOND   = 2'd3;

  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_WRITE,
    OP_NOP_RES,
    OP_START,
    OP_READ_ISSUE,
    OP_READ_RES,
    OP_EP_RD,
    OP_EP_EV,
    OP_RES_UNUSABLE,
    OP_SCLR,
    OP_BINIT,
    OP_POP,
    OP_RES_NOPATH,
    OP_FETCH,
    OP_EXPAND,
    OP_WALK_RD,
    OP_WALK_ST,
    OP_WALK_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic ep_fail;
    logic ep_pass;
    logic ep_goal_phase;
    logic q_empty;
    logic is_goal;
    logic exp_done;
    logic at_start;
    logic out_valid;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/grid_bfs_path_finder_unit.sv
// grid_bfs_path_finder_unit: top level, breadth-first shortest path on a cell grid
// depends on gbpf_pkg, gbpf_ctrl, gbpf_datapath
//
//  channel  direction  transfer when          carries
//  s_*      in         s_tvalid & s_tready    one command item
//  m_*      out        m_tvalid & m_tready    one result per item
//  cfg_*    in         cfg_valid & cfg_ready  grid_cols (index 0), grid_rows (index 1)
//
// write cell and no-op answer directly from idle; a path read reads the path store, then answers
// search: endpoint checks, a seen-map sweep over all 2^(XW+YW) cells, then a pop and
// neighbor expansion per queued cell (one memory port per map) and a walk back per path cell
// after reset the free map is swept blocked over all 2^(XW+YW) cells (1024 by default)
// s_tready is low during that sweep, while an item works or while its result waits on m_tready
`timescale 1ns / 1ps
`default_nettype none

module grid_bfs_path_finder_unit #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // cell_x, cell_y, cell_free, goal_x, goal_y, path_index
  input  wire logic [1:0]  s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // path_length, point_x, point_y
  output logic [1:0]       m_tuser,   // status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  gbpf_pkg::dp_cmd_t  cmd;
  gbpf_pkg::dp_stat_t stat;
  logic [10:0] path_length;
  logic [4:0]  point_x, point_y;

  assign cfg_ready = 1'b1;
  assign m_tvalid  = stat.out_valid;
  assign m_tdata   = {3'd0, point_y, point_x, path_length};

  gbpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .func     (s_tuser),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  gbpf_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cell_x      (s_tdata[4:0]),
    .cell_y      (s_tdata[9:5]),
    .cell_free   (s_tdata[10]),
    .goal_x      (s_tdata[15:11]),
    .goal_y      (s_tdata[20:16]),
    .path_index  (s_tdata[30:21]),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (m_tready),
    .status      (m_tuser),
    .path_length (path_length),
    .point_x     (point_x),
    .point_y     (point_y)
  );

endmodule

`default_nettype wire

>>> hdl/gbpf_datapath.sv
// gbpf_datapath: grid memories, frontier queue, path store, counters and result register
// depends on gbpf_pkg; driven by gbpf_ctrl through dp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module gbpf_datapath #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  gbpf_pkg::dp_cmd_t      cmd,
  output gbpf_pkg::dp_stat_t     stat,
  input  wire logic [4:0]        cell_x,
  input  wire logic [4:0]        cell_y,
  input  wire logic              cell_free,
  input  wire logic [4:0]        goal_x,
  input  wire logic [4:0]        goal_y,
  input  wire logic [9:0]        path_index,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [5:0]        cfg_data,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic [10:0]            path_length,
  output logic [4:0]             point_x,
  output logic [4:0]             point_y
);

  localparam int XW = $clog2(MAX_COLS);
  localparam int YW = $clog2(MAX_ROWS);
  localparam int AW = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam logic [5:0] COLS_RST = (MAX_COLS < 32) ? 6'(MAX_COLS) : 6'd32;
  localparam logic [5:0] ROWS_RST = (MAX_ROWS < 32) ? 6'(MAX_ROWS) : 6'd32;

  // cells are addressed as {y, x}
  logic          free_mem  [DEPTH];
  logic          seen_mem  [DEPTH];
  logic [1:0]    came_mem  [DEPTH];
  logic [AW-1:0] queue_mem [DEPTH];
  logic [AW-1:0] path_mem  [DEPTH];

  logic [5:0]    cols, rows;
  logic [AW-1:0] start_cell, goal_cell, cur, clr, pend_n;
  logic          s_in_grid, g_in_grid, goal_phase, any_free, ep_inb_q, pend_v;
  logic [1:0]    pend_d;
  logic [2:0]    k;
  logic [AW:0]   head, tail, wk, stored_len;
  logic          rd_in_range;
  logic          free_q, seen_q;
  logic [1:0]    came_q;
  logic [AW-1:0] queue_q, path_q;
  logic          out_valid;

  logic [XW-1:0] cx, nbx, bkx;
  logic [YW-1:0] cy, nby, bky;
  logic          nb_ok, hit, ep_inb;
  logic [AW-1:0] nb_cell, free_raddr, path_raddr, in_cell;
  logic          in_on_grid;

  function automatic logic [5:0] clamp_size(input logic [5:0] v, input int max_v);
    logic [5:0] r;
    r = v;
    if (v == 6'd0) r = 6'd1;
    else if (10'(v) > 10'(max_v)) r = 6'(max_v);
    return r;
  endfunction

  assign cx = cur[XW-1:0];
  assign cy = cur[AW-1:XW];

  // neighbor of the current cell in direction k: +x, +y, -x, -y
  always_comb begin
    nbx = cx;
    nby = cy;
    nb_ok = 1'b0;
    unique case (k[1:0])
      2'd0: begin
        nbx = cx + XW'(1);
        nb_ok = (10'(cx) + 10'd1) < 10'(cols);
      end
      2'd1: begin
        nby = cy + YW'(1);
        nb_ok = (10'(cy) + 10'd1) < 10'(rows);
      end
      2'd2: begin
        nbx = cx - XW'(1);
        nb_ok = cx != '0;
      end
      default: begin
        nby = cy - YW'(1);
        nb_ok = cy != '0;
      end
    endcase
  end
  assign nb_cell = {nby, nbx};

  // predecessor along the stored move
  always_comb begin
    bkx = cx;
    bky = cy;
    unique case (came_q)
      2'd0: bkx = cx - XW'(1);
      2'd1: bky = cy - YW'(1);
      2'd2: bkx = cx + XW'(1);
      default: bky = cy + YW'(1);
    endcase
  end

  assign ep_inb     = k[2] ? (goal_phase ? g_in_grid : s_in_grid) : nb_ok;
  assign free_raddr = (cmd.op == gbpf_pkg::OP_EP_RD && k[2]) ? cur : nb_cell;
  assign hit        = ep_inb_q & free_q;
  assign in_on_grid = (10'(cell_x) < 10'(MAX_COLS)) && (10'(cell_y) < 10'(MAX_ROWS));
  assign in_cell    = {YW'(cell_y), XW'(cell_x)};
  assign path_raddr = AW'(stored_len - (AW+1)'(1) - (AW+1)'(path_index));

  // memories
  always_ff @(posedge clk) begin
    free_q  <= free_mem[free_raddr];
    seen_q  <= seen_mem[nb_cell];
    came_q  <= came_mem[cur];
    queue_q <= queue_mem[head[AW-1:0]];
    path_q  <= path_mem[path_raddr];
    if (cmd.op == gbpf_pkg::OP_CLR) free_mem[clr] <= 1'b0;
    else if (cmd.op == gbpf_pkg::OP_WRITE && in_on_grid) free_mem[in_cell] <= cell_free;
    if (cmd.op == gbpf_pkg::OP_SCLR) seen_mem[clr] <= 1'b0;
    else if (cmd.op == gbpf_pkg::OP_BINIT) seen_mem[start_cell] <= 1'b1;
    else if (cmd.op == gbpf_pkg::OP_EXPAND && pend_v && free_q && !seen_q) begin
      seen_mem[pend_n] <= 1'b1;
    end
    if (cmd.op == gbpf_pkg::OP_EXPAND && pend_v && free_q && !seen_q) begin
      came_mem[pend_n] <= pend_d;
    end
    if (cmd.op == gbpf_pkg::OP_BINIT) queue_mem[0] <= start_cell;
    else if (cmd.op == gbpf_pkg::OP_EXPAND && pend_v && free_q && !seen_q) begin
      queue_mem[tail[AW-1:0]] <= pend_n;
    end
    if (cmd.op == gbpf_pkg::OP_WALK_RD || cmd.op == gbpf_pkg::OP_WALK_END) begin
      path_mem[wk[AW-1:0]] <= cur;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= COLS_RST;
      rows <= ROWS_RST;
      clr <= '0;
      head <= '0;
      tail <= '0;
      stored_len <= '0;
      out_valid <= 1'b0;
      k <= '0;
      goal_phase <= 1'b0;
      pend_v <= 1'b0;
      wk <= '0;
    end else begin
      if (cfg_valid && cfg_index == gbpf_pkg::CFG_COLS) cols <= clamp_size(cfg_data, MAX_COLS);
      if (cfg_valid && cfg_index == gbpf_pkg::CFG_ROWS) rows <= clamp_size(cfg_data, MAX_ROWS);
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (cmd.op)
        gbpf_pkg::OP_CLR, gbpf_pkg::OP_SCLR: clr <= clr + AW'(1);
        gbpf_pkg::OP_WRITE, gbpf_pkg::OP_NOP_RES, gbpf_pkg::OP_READ_RES,
        gbpf_pkg::OP_RES_UNUSABLE, gbpf_pkg::OP_RES_NOPATH: out_valid <= 1'b1;
        gbpf_pkg::OP_START: begin
          stored_len <= '0;
          k <= '0;
          goal_phase <= 1'b0;
          clr <= '0;
        end
        gbpf_pkg::OP_EP_EV: begin
          if (k[2] && !goal_phase) begin
            goal_phase <= 1'b1;
            k <= '0;
          end else begin
            k <= k + 3'd1;
          end
        end
        gbpf_pkg::OP_BINIT: begin
          head <= '0;
          tail <= (AW+1)'(1);
        end
        gbpf_pkg::OP_POP: head <= head + (AW+1)'(1);
        gbpf_pkg::OP_FETCH: begin
          k <= '0;
          pend_v <= 1'b0;
          wk <= '0;
        end
        gbpf_pkg::OP_EXPAND: begin
          pend_v <= !k[2] && nb_ok;
          k <= k + 3'd1;
          if (pend_v && free_q && !seen_q) tail <= tail + (AW+1)'(1);
        end
        gbpf_pkg::OP_WALK_ST: wk <= wk + (AW+1)'(1);
        gbpf_pkg::OP_WALK_END: begin
          stored_len <= wk + (AW+1)'(1);
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gbpf_pkg::OP_START: begin
        start_cell <= in_cell;
        goal_cell <= {YW'(goal_y), XW'(goal_x)};
        cur <= in_cell;
        s_in_grid <= (6'(cell_x) < cols) && (6'(cell_y) < rows);
        g_in_grid <= (6'(goal_x) < cols) && (6'(goal_y) < rows);
        any_free <= 1'b0;
      end
      gbpf_pkg::OP_EP_RD: ep_inb_q <= ep_inb;
      gbpf_pkg::OP_EP_EV: begin
        if (k[2]) begin
          cur <= goal_cell;
          any_free <= 1'b0;
        end else begin
          any_free <= any_free | hit;
        end
      end
      gbpf_pkg::OP_FETCH: cur <= queue_q;
      gbpf_pkg::OP_EXPAND: begin
        pend_n <= nb_cell;
        pend_d <= k[1:0];
      end
      gbpf_pkg::OP_WALK_ST: cur <= {bky, bkx};
      gbpf_pkg::OP_READ_ISSUE: rd_in_range <= 17'(path_index) < 17'(stored_len);
      default: ;
    endcase
    unique case (cmd.op)
      gbpf_pkg::OP_WRITE, gbpf_pkg::OP_NOP_RES: begin
        status <= gbpf_pkg::STAT_OK;
        path_length <= 11'(stored_len);
        point_x <= '0;
        point_y <= '0;
      end
      gbpf_pkg::OP_RES_UNUSABLE, gbpf_pkg::OP_RES_NOPATH: begin
        status <= (cmd.op == gbpf_pkg::OP_RES_UNUSABLE) ? gbpf_pkg::STAT_UNUSABLE
                                                       : gbpf_pkg::STAT_NO_PATH;
        path_length <= '0;
        point_x <= '0;
        point_y <= '0;
      end
      gbpf_pkg::OP_WALK_END: begin
        status <= gbpf_pkg::STAT_OK;
        path_length <= 11'(wk + (AW+1)'(1));
        point_x <= '0;
        point_y <= '0;
      end
      gbpf_pkg::OP_READ_RES: begin
        status <= rd_in_range ? gbpf_pkg::STAT_OK : gbpf_pkg::STAT_BEYOND;
        path_length <= 11'(stored_len);
        point_x <= rd_in_range ? 5'(path_q[XW-1:0]) : 5'd0;
        point_y <= rd_in_range ? 5'(path_q[AW-1:XW]) : 5'd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.clr_done      = clr == {AW{1'b1}};
    stat.ep_fail       = k[2] && !(hit && any_free);
    stat.ep_pass       = k[2] && hit && any_free;
    stat.ep_goal_phase = goal_phase;
    stat.q_empty       = head == tail;
    stat.is_goal       = queue_q == goal_cell;
    stat.exp_done      = k[2];
    stat.at_start      = cur == start_cell;
    stat.out_valid     = out_valid;
  end

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("queue head passed tail");
  a_tail_depth: assert property (@(posedge clk) disable iff (rst) tail <= (AW+1)'(DEPTH))
    else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.op == gbpf_pkg::OP_POP |-> head != tail)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> hdl/gbpf_ctrl.sv
// gbpf_ctrl: controller state machine of the grid path finder
// depends on gbpf_pkg; commands gbpf_datapath
`timescale 1ns / 1ps
`default_nettype none

module gbpf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [1:0]       func,
  output logic                  in_ready,
  output gbpf_pkg::dp_cmd_t     cmd,
  input  gbpf_pkg::dp_stat_t    stat
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EP_RD, S_EP_EV, S_SCLR, S_BINIT, S_POP, S_FETCH,
    S_EXPAND, S_WALK_RD, S_WALK_ST, S_READ
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && !stat.out_valid;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd.op = gbpf_pkg::OP_NONE;
    unique case (state)
      S_CLR: begin
        cmd.op = gbpf_pkg::OP_CLR;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            gbpf_pkg::FUNC_WRITE: cmd.op = gbpf_pkg::OP_WRITE;
            gbpf_pkg::FUNC_SEARCH: begin
              cmd.op = gbpf_pkg::OP_START;
              state_next = S_EP_RD;
            end
            gbpf_pkg::FUNC_READ: begin
              cmd.op = gbpf_pkg::OP_READ_ISSUE;
              state_next = S_READ;
            end
            default: cmd.op = gbpf_pkg::OP_NOP_RES;
          endcase
        end
      end
      S_EP_RD: begin
        cmd.op = gbpf_pkg::OP_EP_RD;
        state_next = S_EP_EV;
      end
      S_EP_EV: begin
        priority if (stat.ep_fail) begin
          cmd.op = gbpf_pkg::OP_RES_UNUSABLE;
          state_next = S_IDLE;
        end else if (stat.ep_pass && stat.ep_goal_phase) begin
          state_next = S_SCLR;
        end else begin
          cmd.op = gbpf_pkg::OP_EP_EV;
          state_next = S_EP_RD;
        end
      end
      S_SCLR: begin
        cmd.op = gbpf_pkg::OP_SCLR;
        if (stat.clr_done) state_next = S_BINIT;
      end
      S_BINIT: begin
        cmd.op = gbpf_pkg::OP_BINIT;
        state_next = S_POP;
      end
      S_POP: begin
        if (stat.q_empty) begin
          cmd.op = gbpf_pkg::OP_RES_NOPATH;
          state_next = S_IDLE;
        end else begin
          cmd.op = gbpf_pkg::OP_POP;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.op = gbpf_pkg::OP_FETCH;
        state_next = stat.is_goal ? S_WALK_RD : S_EXPAND;
      end
      S_EXPAND: begin
        cmd.op = gbpf_pkg::OP_EXPAND;
        if (stat.exp_done) state_next = S_POP;
      end
      S_WALK_RD: begin
        if (stat.at_start) begin
          cmd.op = gbpf_pkg::OP_WALK_END;
          state_next = S_IDLE;
        end else begin
          cmd.op = gbpf_pkg::OP_WALK_RD;
          state_next = S_WALK_ST;
        end
      end
      S_WALK_ST: begin
        cmd.op = gbpf_pkg::OP_WALK_ST;
        state_next = S_WALK_RD;
      end
      S_READ: begin
        cmd.op = gbpf_pkg::OP_READ_RES;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else state <= state_next;
  end

  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    accept && func == gbpf_pkg::FUNC_SEARCH |=> state == S_EP_RD)
    else $error("search did not start endpoint check");
  a_nopath_result: assert property (@(posedge clk) disable iff (rst)
    state == S_POP && stat.q_empty |=> stat.out_valid)
    else $error("no-path result not presented");
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.out_valid && state == S_IDLE)
    else $error("input taken while result pending");

endmodule

`default_nettype wire
